@@ src/npci_pkg.sv @@
`timescale 1ns / 1ps

package npci_pkg;

  // Field widths of the stream items.
  localparam int unsigned COLOR_W   = 8;
  localparam int unsigned ENTRY_W   = 3 * COLOR_W;
  localparam int unsigned SQ_W      = 2 * COLOR_W;
  // Three squared 8-bit differences sum to at most 195075.
  localparam int unsigned DIST_W    = 18;
  localparam int unsigned PSIZE_W   = 9;
  localparam logic [PSIZE_W-1:0] PSIZE_RESET = 9'd256;

  // Configuration register indexes.
  localparam int unsigned REG_IDX_W = 1;
  typedef enum logic [REG_IDX_W-1:0] {
    REG_SEARCH_LEN = 1'b0,
    REG_UNUSED     = 1'b1
  } reg_idx_e;

  // Kind of an input item.
  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_PIXEL = 1'b1
  } action_e;

  // One input item as it travels down the cell chain.
  typedef struct packed {
    action_e            action;
    logic [7:0]         entry_index;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               last_pixel;
  } item_t;

  // Square of the absolute difference of two color components.
  function automatic logic [SQ_W-1:0] sq_diff(input logic [COLOR_W-1:0] a,
                                              input logic [COLOR_W-1:0] b);
    logic [COLOR_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

endpackage

@@ src/npci_apb_regs.sv @@
`timescale 1ns / 1ps

module npci_apb_regs import npci_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic [PSIZE_W-1:0] search_len_o
);

  logic [PSIZE_W-1:0] search_len_q, search_len_d;
  reg_idx_e           reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // Register write decode.
  always_comb begin
    search_len_d = search_len_q;
    unique case (reg_idx)
      REG_SEARCH_LEN: begin
        if (wr_en) begin
          search_len_d = pwdata[PSIZE_W-1:0];
        end
      end
      default: begin
        search_len_d = search_len_q;
      end
    endcase
  end

  // Register read decode.
  always_comb begin
    unique case (reg_idx)
      REG_SEARCH_LEN: prdata = 32'(search_len_q);
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_len_q <= PSIZE_RESET;
    end else begin
      search_len_q <= search_len_d;
    end
  end

  assign search_len_o = search_len_q;

endmodule

@@ src/npci_cell.sv @@
`timescale 1ns / 1ps

// One palette entry and the two pipeline stages that compare a pixel with it.
module npci_cell import npci_pkg::*; #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned IDX_W    = 8,
  parameter int unsigned CNT_W    = 9
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  logic [CNT_W-1:0]  count_i,
  input  logic              valid_i,
  input  item_t             item_i,
  input  logic [DIST_W-1:0] best_dist_i,
  input  logic [IDX_W-1:0]  best_idx_i,
  output logic              valid_o,
  output item_t             item_o,
  output logic [DIST_W-1:0] best_dist_o,
  output logic [IDX_W-1:0]  best_idx_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [ENTRY_W-1:0] entry_q;
  logic               load_hit;
  logic               in_range;

  // Stage A registers: squared component differences.
  logic              valid_a_q;
  item_t             item_a_q;
  logic [DIST_W-1:0] best_dist_a_q;
  logic [IDX_W-1:0]  best_idx_a_q;
  logic [SQ_W-1:0]   sq_r_q, sq_g_q, sq_b_q;
  logic [SQ_W-1:0]   sq_r_d, sq_g_d, sq_b_d;

  // Stage B registers: running best after this entry.
  logic              valid_b_q;
  item_t             item_b_q;
  logic [DIST_W-1:0] best_dist_b_q, best_dist_b_d;
  logic [IDX_W-1:0]  best_idx_b_q, best_idx_b_d;
  logic [DIST_W-1:0] cand_dist;

  // A load item writes this entry as it passes; items behind it see the new color.
  assign load_hit = valid_i && (item_i.action == ACT_LOAD) &&
                    (32'(item_i.entry_index) == 32'(CELL_IDX));

  always_ff @(posedge clk_i) begin
    if (advance_i && load_hit) begin
      entry_q <= {item_i.red, item_i.green, item_i.blue};
    end
  end

  // Stage A: component differences squared.
  assign sq_r_d = sq_diff(entry_q[23:16], item_i.red);
  assign sq_g_d = sq_diff(entry_q[15:8],  item_i.green);
  assign sq_b_d = sq_diff(entry_q[7:0],   item_i.blue);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else if (advance_i) begin
      valid_a_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      item_a_q      <= item_i;
      best_dist_a_q <= best_dist_i;
      best_idx_a_q  <= best_idx_i;
      sq_r_q        <= sq_r_d;
      sq_g_q        <= sq_g_d;
      sq_b_q        <= sq_b_d;
    end
  end

  // Stage B: sum and strict compare, so a tie keeps the lower index.
  assign in_range  = 32'(count_i) > 32'(CELL_IDX);
  assign cand_dist = DIST_W'(sq_r_q) + DIST_W'(sq_g_q) + DIST_W'(sq_b_q);

  always_comb begin
    best_dist_b_d = best_dist_a_q;
    best_idx_b_d  = best_idx_a_q;
    if (in_range && (cand_dist < best_dist_a_q)) begin
      best_dist_b_d = cand_dist;
      best_idx_b_d  = MY_IDX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_b_q <= 1'b0;
    end else if (advance_i) begin
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      item_b_q      <= item_a_q;
      best_dist_b_q <= best_dist_b_d;
      best_idx_b_q  <= best_idx_b_d;
    end
  end

  assign valid_o     = valid_b_q;
  assign item_o      = item_b_q;
  assign best_dist_o = best_dist_b_q;
  assign best_idx_o  = best_idx_b_q;

endmodule

@@ src/nearest_palette_color_index_top.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Transfer carries
// s_axis    in         load entry or pixel: tuser = action, tlast = last_pixel,
//                      tdata = entry_index, red, green, blue
// m_axis    out        one result per pixel: tdata = palette_index, tlast = image_end
// APB       in/out     register 0 (byte address 0): search length
//
// One item enters per clock unless m_axis stalls; a pixel's result passes through the chain
// of palette cells (two stages per entry, the first loaded at the transfer edge) and then
// the output register before it is presented.
// Load items travel the same chain and write their entry on the way, so order is kept.
// Reset clears all valid bits and sets the search length to 256; palette contents are undefined.
// A stall on m_axis freezes the whole chain, so no item is lost or repeated.
module nearest_palette_color_index_top import npci_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // entry_index, red, green, blue (from bit 0 up)
  input  logic        s_axis_tuser,  // action
  input  logic        s_axis_tlast,
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // palette_index
  output logic        m_axis_tlast,
  // Configuration.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IDX_W = $clog2(PALETTE_DEPTH);
  localparam int unsigned CNT_W = $clog2(PALETTE_DEPTH + 1);

  logic [PSIZE_W-1:0] search_len;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               advance;

  logic              valid_c [PALETTE_DEPTH+1];
  item_t             item_c  [PALETTE_DEPTH+1];
  logic [DIST_W-1:0] dist_c  [PALETTE_DEPTH+1];
  logic [IDX_W-1:0]  idx_c   [PALETTE_DEPTH+1];

  logic              out_valid_q;
  logic [7:0]        out_data_q;
  logic              out_last_q;
  logic [IDX_W+7:0]  idx_ext;
  logic              end_pixel;

  npci_apb_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .search_len_o (search_len)
  );

  // Number of entries searched: zero acts as one, large sizes saturate.
  always_comb begin
    if (search_len == '0) begin
      count_d = CNT_W'(1);
    end else if (32'(search_len) > PALETTE_DEPTH) begin
      count_d = CNT_W'(PALETTE_DEPTH);
    end else begin
      count_d = CNT_W'(search_len);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CNT_W'(1);
    end else begin
      count_q <= count_d;
    end
  end

  // The chain moves whenever the output register is free or being drained.
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = advance;

  // Chain head: unpack the transfer, start with a distance no entry can exceed.
  assign valid_c[0]             = s_axis_tvalid;
  assign item_c[0].action       = action_e'(s_axis_tuser);
  assign item_c[0].entry_index  = s_axis_tdata[7:0];
  assign item_c[0].red          = s_axis_tdata[15:8];
  assign item_c[0].green        = s_axis_tdata[23:16];
  assign item_c[0].blue         = s_axis_tdata[31:24];
  assign item_c[0].last_pixel   = s_axis_tlast;
  assign dist_c[0]              = '1;
  assign idx_c[0]               = '0;

  // One cell per palette entry.
  for (genvar j = 0; j < PALETTE_DEPTH; j++) begin : g_cell
    npci_cell #(
      .CELL_IDX (j),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .advance_i   (advance),
      .count_i     (count_q),
      .valid_i     (valid_c[j]),
      .item_i      (item_c[j]),
      .best_dist_i (dist_c[j]),
      .best_idx_i  (idx_c[j]),
      .valid_o     (valid_c[j+1]),
      .item_o      (item_c[j+1]),
      .best_dist_o (dist_c[j+1]),
      .best_idx_o  (idx_c[j+1])
    );
  end

  // Output register: only pixel items leave a result.
  assign end_pixel = valid_c[PALETTE_DEPTH] &&
                     (item_c[PALETTE_DEPTH].action == ACT_PIXEL);
  assign idx_ext   = (IDX_W + 8)'(idx_c[PALETTE_DEPTH]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= end_pixel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= idx_ext[7:0];
      out_last_q <= item_c[PALETTE_DEPTH].last_pixel;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // The searched count stays within the store.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) && (32'(count_q) <= PALETTE_DEPTH))
    else $error("search count out of range");

  // A winning index lies inside the searched range.
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_pixel |-> (32'(idx_c[PALETTE_DEPTH]) < 32'(count_q)))
    else $error("winning index beyond searched entries");

  // A frozen chain keeps its last stage.
  a_chain_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(valid_c[PALETTE_DEPTH]))
    else $error("chain moved during a stall");

  // A new result comes only from a pixel at the end of the chain.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(end_pixel))
    else $error("result without a pixel");

endmodule

@@ verif/tb_nearest_palette_color_index_top.sv @@
`timescale 1ns / 1ps

// Checks the palette quantizer against a cycle-free model of the palette.
// A short table of directed rows comes first: palette size zero, ties,
// the extreme colors and a write to the unused register. Then the whole
// palette is filled, and random loads and pixels run under a series of
// palette sizes with random idling on both streams.
module tb_nearest_palette_color_index_top;
  import npci_pkg::*;

  localparam int unsigned DEPTH         = 256;
  localparam int unsigned CHAIN_LATENCY = 2 * DEPTH + 1;
  localparam int unsigned SINK_HOLD     = 2000;
  localparam int unsigned PHASE_COUNT   = 9;
  localparam int unsigned PHASE_ITEMS   = 165;
  localparam logic [2:0]  ADDR_SEARCH_LEN = {REG_SEARCH_LEN, 2'b00};
  localparam logic [2:0]  ADDR_UNUSED     = {REG_UNUSED, 2'b00};

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_LOAD,
    ROW_PIXEL
  } row_kind_e;

  // One row of the directed table. The expected index is used only when typed is set.
  typedef struct packed {
    row_kind_e   kind;
    logic [2:0]  addr;
    logic [31:0] value;
    logic [7:0]  idx;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
    logic        typed;
    logic [7:0]  exp_index;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] index;
    logic       image_end;
  } palette_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // entry_index, red, green, blue (from bit 0 up)
  logic        s_axis_tuser = 1'b0;  // action
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;  // palette_index
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the palette and of the size register.
  logic [23:0]     palette_mem [DEPTH];
  logic [8:0]      search_len_q = PSIZE_RESET;
  palette_result_t awaited_results [$];
  stim_row_t       dir_rows [$];

  bit          idle_on = 1'b1;
  bit          sink_hold_req = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned pixels_sent = 0;
  int unsigned loads_sent = 0;
  int unsigned results_seen = 0;
  int unsigned cfg_writes = 0;

  nearest_palette_color_index_top #(
    .PALETTE_DEPTH(DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Limit on the whole run, far above the slowest correct run.
  initial begin
    #10_000_000;
    $display("Timeout with %0d results still awaited.", awaited_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Nearest entry by squared RGB distance; the first entry wins a tie.
  function automatic logic [7:0] predict_nearest(input logic [7:0] r, input logic [7:0] g,
                                                 input logic [7:0] b);
    int unsigned span;
    int unsigned best;
    int unsigned best_d;
    int unsigned d;
    int          dr;
    int          dg;
    int          db;
    span = (search_len_q == 0) ? 1 : ((search_len_q > DEPTH) ? DEPTH : search_len_q);
    best = 0;
    best_d = 32'hFFFF_FFFF;
    for (int unsigned j = 0; j < span; j++) begin
      dr = int'(palette_mem[j][23:16]) - int'(r);
      dg = int'(palette_mem[j][15:8]) - int'(g);
      db = int'(palette_mem[j][7:0]) - int'(b);
      d = dr * dr + dg * dg + db * db;
      if (d < best_d) begin
        best_d = d;
        best = j;
      end
    end
    return best[7:0];
  endfunction

  // Channel value that favors the two extremes.
  function automatic logic [7:0] pick_channel();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) begin
      return 8'h00;
    end else if (sel == 1) begin
      return 8'hFF;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Offer one item, wait for its transfer and record what it should produce.
  task automatic offer_item(input action_e act, input logic [7:0] idx, input logic [7:0] r,
                            input logic [7:0] g, input logic [7:0] b, input logic last,
                            input logic typed, input logic [7:0] typed_index);
    palette_result_t res;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tlast  <= last;
    s_axis_tdata  <= {b, g, r, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (act == ACT_LOAD) begin
      palette_mem[idx] = {r, g, b};
      loads_sent++;
    end else begin
      res.index = typed ? typed_index : predict_nearest(r, g, b);
      res.image_end = last;
      awaited_results.push_back(res);
      pixels_sent++;
    end
  endtask

  // Stop offering and wait for every awaited result; the tail covers loads still in flight.
  task automatic drain_block(input bit with_tail);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
    if (with_tail) begin
      repeat (CHAIN_LATENCY + 16) @(posedge clk_i);
    end
  endtask

  // Setup cycle, then access cycle; the register takes the value at the end of the access.
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx_e'(addr[2]) == REG_SEARCH_LEN) begin
      search_len_q = data[8:0];
    end
    cfg_writes++;
  endtask

  // Output side ready: random stalls, plus one long hold on request.
  initial begin
    forever begin
      if (sink_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (SINK_HOLD) @(posedge clk_i);
        sink_hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  // Compare each result transfer with the oldest awaited result.
  always @(posedge clk_i) begin : result_check
    palette_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        flag_error($sformatf("unexpected result index %0d end %0b", m_axis_tdata,
                             m_axis_tlast));
      end else begin
        want = awaited_results.pop_front();
        if (m_axis_tdata !== want.index) begin
          flag_error($sformatf("palette_index %0d, wanted %0d", m_axis_tdata, want.index));
        end
        if (m_axis_tlast !== want.image_end) begin
          flag_error($sformatf("image_end %0b, wanted %0b", m_axis_tlast, want.image_end));
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t   row;
    logic [8:0]  size_plan [PHASE_COUNT];
    logic [7:0]  idx;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [23:0] copy;
    int unsigned span;

    // Directed table: the first rows run with palette size zero, which searches one entry.
    dir_rows.push_back('{ROW_CFG,   ADDR_SEARCH_LEN, 32'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                         1'b0, 1'b0, 8'd0});
    dir_rows.push_back('{ROW_LOAD,  3'd0, 32'd0, 8'd0, 8'd10, 8'd20, 8'd30,
                         1'b0, 1'b0, 8'd0});
    dir_rows.push_back('{ROW_PIXEL, 3'd0, 32'd0, 8'h5A, 8'd255, 8'd255, 8'd255,
                         1'b1, 1'b1, 8'd0});
    dir_rows.push_back('{ROW_PIXEL, 3'd0, 32'd0, 8'hA5, 8'd0, 8'd0, 8'd0,
                         1'b0, 1'b1, 8'd0});
    // Entries 1 and 2 are equal, so a white pixel ties between them.
    dir_rows.push_back('{ROW_LOAD,  3'd0, 32'd0, 8'd1, 8'd255, 8'd255, 8'd255,
                         1'b0, 1'b0, 8'd0});
    dir_rows.push_back('{ROW_LOAD,  3'd0, 32'd0, 8'd2, 8'd255, 8'd255, 8'd255,
                         1'b1, 1'b0, 8'd0});
    dir_rows.push_back('{ROW_LOAD,  3'd0, 32'd0, 8'd3, 8'd0, 8'd0, 8'd0,
                         1'b0, 1'b0, 8'd0});
    dir_rows.push_back('{ROW_LOAD,  3'd0, 32'd0, 8'd255, 8'd0, 8'd255, 8'd0,
                         1'b0, 1'b0, 8'd0});
    dir_rows.push_back('{ROW_CFG,   ADDR_SEARCH_LEN, 32'd4, 8'd0, 8'd0, 8'd0, 8'd0,
                         1'b0, 1'b0, 8'd0});
    dir_rows.push_back('{ROW_PIXEL, 3'd0, 32'd0, 8'd0, 8'd255, 8'd255, 8'd255,
                         1'b0, 1'b1, 8'd1});
    dir_rows.push_back('{ROW_PIXEL, 3'd0, 32'd0, 8'hFF, 8'd0, 8'd0, 8'd0,
                         1'b1, 1'b1, 8'd3});
    dir_rows.push_back('{ROW_PIXEL, 3'd0, 32'd0, 8'd0, 8'd10, 8'd20, 8'd30,
                         1'b0, 1'b1, 8'd0});
    // A write to the unused register must leave the size at four.
    dir_rows.push_back('{ROW_CFG,   ADDR_UNUSED, 32'd1, 8'd0, 8'd0, 8'd0, 8'd0,
                         1'b0, 1'b0, 8'd0});
    dir_rows.push_back('{ROW_PIXEL, 3'd0, 32'd0, 8'd7, 8'd0, 8'd0, 8'd0,
                         1'b0, 1'b1, 8'd3});
    dir_rows.push_back('{ROW_PIXEL, 3'd0, 32'd0, 8'd0, 8'd128, 8'd64, 8'd200,
                         1'b0, 1'b0, 8'd0});
    dir_rows.push_back('{ROW_PIXEL, 3'd0, 32'd0, 8'hFF, 8'd255, 8'd0, 8'd255,
                         1'b1, 1'b0, 8'd0});

    size_plan[0] = 9'd511;
    size_plan[1] = 9'd256;
    size_plan[2] = 9'd1;
    size_plan[3] = 9'd0;
    size_plan[4] = 9'd2;
    size_plan[5] = 9'($urandom_range(3, 255));
    size_plan[6] = 9'($urandom_range(257, 510));
    size_plan[7] = 9'd128;
    size_plan[8] = 9'd256;

    // Hold reset low, then release it.
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table.
    foreach (dir_rows[k]) begin
      row = dir_rows[k];
      if (row.kind == ROW_CFG) begin
        drain_block(1'b1);
        apb_write(row.addr, row.value);
      end else begin
        offer_item(row.kind == ROW_LOAD ? ACT_LOAD : ACT_PIXEL, row.idx, row.red,
                   row.green, row.blue, row.last, row.typed, row.exp_index);
      end
    end

    // Write every entry once, so that any palette size searches written entries only.
    for (int unsigned e = 0; e < DEPTH; e++) begin
      if (e > 0 && $urandom_range(0, 5) == 0) begin
        copy = palette_mem[$urandom_range(0, e - 1)];
        offer_item(ACT_LOAD, 8'(e), copy[23:16], copy[15:8], copy[7:0], 1'($urandom()),
                   1'b0, 8'd0);
      end else begin
        offer_item(ACT_LOAD, 8'(e), pick_channel(), pick_channel(), pick_channel(),
                   1'($urandom()), 1'b0, 8'd0);
      end
    end

    // Random phases, one palette size each; the last phase runs without idling.
    for (int unsigned ph = 0; ph < PHASE_COUNT; ph++) begin
      drain_block(1'b1);
      apb_write(ADDR_SEARCH_LEN, {23'd0, size_plan[ph]});
      idle_on = (ph != PHASE_COUNT - 1);
      if (ph == 1) begin
        sink_hold_req = 1'b1;
      end
      span = (search_len_q == 0) ? 1 :
             ((search_len_q > DEPTH) ? DEPTH : search_len_q);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 4 && n == PHASE_ITEMS / 2) begin
          drain_block(1'b0);
        end
        idx = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 6) == 0) begin
          // Load, often a copy of another entry so that ties come up.
          if ($urandom_range(0, 2) == 0) begin
            copy = palette_mem[$urandom_range(0, DEPTH - 1)];
            {r, g, b} = copy;
          end else begin
            r = pick_channel();
            g = pick_channel();
            b = pick_channel();
          end
          offer_item(ACT_LOAD, idx, r, g, b, 1'($urandom()), 1'b0, 8'd0);
        end else begin
          // Pixel, sometimes an exact copy of a searched entry.
          if ($urandom_range(0, 3) == 0) begin
            copy = palette_mem[$urandom_range(0, span - 1)];
            {r, g, b} = copy;
          end else begin
            r = pick_channel();
            g = pick_channel();
            b = pick_channel();
          end
          offer_item(ACT_PIXEL, idx, r, g, b, 1'($urandom_range(0, 7) == 0), 1'b0, 8'd0);
        end
      end
    end

    drain_block(1'b1);
    $display("Run covered %0d pixel and %0d load transfers, %0d results checked,",
             pixels_sent, loads_sent, results_seen);
    $display("over %0d register writes from size zero to 511 and one long output stall.",
             cfg_writes);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches found.", mismatch_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/npci_pkg.sv
src/npci_apb_regs.sv
src/npci_cell.sv
src/nearest_palette_color_index_top.sv
verif/tb_nearest_palette_color_index_top.sv
